// ----- sv/sed_pkg.sv -----
// sed_pkg: shared types, character codes and decode helpers for the string
// escape decoder. No dependencies.
`default_nettype none

package sed_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_HEX2   = 3'd3,
    MODE_ERR    = 3'd4
  } mode_e;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADESC = 2'd1;
  localparam logic [1:0] ST_BADHEX = 2'd2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef struct packed {
    mode_e      mode;
    logic [3:0] high_nibble;
    logic [1:0] error_status;
  } sed_state_t;

  localparam sed_state_t SED_STATE_RST = '{mode: MODE_NORMAL, high_nibble: 4'd0,
                                           error_status: ST_OK};

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_out;
    logic       string_end;
    logic [1:0] status;
  } sed_result_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h61 + 8'd10)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h41 + 8'd10)};
    end
    return v;
  endfunction

  // bit 8 set: escape letter not allowed
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] v;
    case (c)
      CH_QUOTE:  v = {1'b0, CH_QUOTE};
      CH_DQUOTE: v = {1'b0, CH_DQUOTE};
      CH_BSLASH: v = {1'b0, CH_BSLASH};
      CH_N:      v = 9'h00A;
      CH_R:      v = 9'h00D;
      CH_T:      v = 9'h009;
      CH_B:      v = 9'h008;
      CH_F:      v = 9'h00C;
      CH_V:      v = 9'h00B;
      CH_ZERO:   v = 9'h000;
      CH_A:      v = 9'h007;
      default:   v = 9'h100;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sed_if.sv -----
// sed_in_if / sed_out_if: valid/ready channels for raw string bytes and
// decoded results. Depends on nothing.
`default_nettype none

interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sed_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] char_out;
  logic       string_end;
  logic [1:0] status;

  modport source (output valid, output char_valid, output char_out,
                  output string_end, output status, input ready);
  modport sink   (input valid, input char_valid, input char_out,
                  input string_end, input status, output ready);
endinterface

`default_nettype wire

// ----- sv/sed_decode.sv -----
// sed_decode: escape decode step for one byte: next decoder state and result.
// Depends on sed_pkg.
`default_nettype none

module sed_decode (
  input  sed_pkg::sed_state_t  cur_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output sed_pkg::sed_state_t  nxt_o,
  output sed_pkg::sed_result_t res_o
);
  import sed_pkg::*;

  logic [4:0] hex;
  logic [8:0] esc;
  sed_state_t nxt;

  assign hex = hex_value(byte_i);
  assign esc = simple_escape(byte_i);

  always_comb begin
    nxt              = cur_i;
    res_o.char_valid = 1'b0;
    res_o.char_out   = 8'h00;
    res_o.string_end = last_i;
    case (cur_i.mode)
      MODE_ESC: begin
        if (byte_i == CH_X) begin
          if (last_i) begin
            nxt.error_status = ST_BADHEX;
            nxt.mode         = MODE_ERR;
          end else begin
            nxt.mode = MODE_HEX1;
          end
        end else if (esc[8]) begin
          nxt.error_status = ST_BADESC;
          nxt.mode         = MODE_ERR;
        end else begin
          res_o.char_valid = 1'b1;
          res_o.char_out   = esc[7:0];
          nxt.mode         = MODE_NORMAL;
        end
      end
      MODE_HEX1: begin
        if (last_i || hex[4]) begin
          nxt.error_status = ST_BADHEX;
          nxt.mode         = MODE_ERR;
        end else begin
          nxt.high_nibble = hex[3:0];
          nxt.mode        = MODE_HEX2;
        end
      end
      MODE_HEX2: begin
        if (hex[4]) begin
          nxt.error_status = ST_BADHEX;
          nxt.mode         = MODE_ERR;
        end else begin
          res_o.char_valid = 1'b1;
          res_o.char_out   = {cur_i.high_nibble, hex[3:0]};
          nxt.mode         = MODE_NORMAL;
        end
      end
      MODE_ERR: begin
      end
      default: begin
        if (byte_i == CH_BSLASH) begin
          if (last_i) begin
            nxt.error_status = ST_BADESC;
            nxt.mode         = MODE_ERR;
          end else begin
            nxt.mode = MODE_ESC;
          end
        end else begin
          res_o.char_valid = 1'b1;
          res_o.char_out   = byte_i;
        end
      end
    endcase
    res_o.status = nxt.error_status;
    nxt_o        = last_i ? SED_STATE_RST : nxt;
  end

endmodule

`default_nettype wire

// ----- sv/string_escape_decoder.sv -----
// string_escape_decoder: top level. Input request register, decode step,
// result register. Depends on sed_pkg, sed_in_if, sed_out_if, sed_decode.
//
//   channel  | dir | payload
//   req_i    | in  | in_byte[7:0], in_last
//   res_o    | out | char_valid, char_out[7:0], string_end, status[1:0]
//
// One result per request. Sustained rate: one request per cycle while
// res_o.ready holds; input and result registers each advance whenever the
// stage after them is empty or draining.
// Reset clears the valid bits and returns the decoder to normal mode.
// A stalled result holds both stages; ready drops only when both are full.
`default_nettype none

module string_escape_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  sed_in_if.sink            req_i,
  sed_out_if.source         res_o
);
  import sed_pkg::*;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_vld_q;
  sed_result_t out_q;
  sed_state_t  state_q;
  sed_state_t  state_d;
  sed_result_t res_d;
  logic        out_adv;
  logic        in_adv;

  assign out_adv   = !out_vld_q || res_o.ready;
  assign in_adv    = in_vld_q && out_adv;
  assign req_i.ready = !in_vld_q || out_adv;

  sed_decode u_decode (
    .cur_i  (state_q),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= SED_STATE_RST;
    end else begin
      if (req_i.ready) begin
        in_vld_q <= req_i.valid;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
      if (in_adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_byte_q <= req_i.in_byte;
      in_last_q <= req_i.in_last;
    end
    if (in_adv) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.char_valid = out_q.char_valid;
  assign res_o.char_out   = out_q.char_out;
  assign res_o.string_end = out_q.string_end;
  assign res_o.status     = out_q.status;

endmodule

`default_nettype wire
